// ===== rtl/core/sibt_pkg.sv =====
// Shared types, constants and the divider step for the allocation table translator.
`default_nettype none
package sibt_pkg;

  localparam int TABLE_SLOTS = 65536;
  localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
  localparam int NUM_W       = 40;
  localparam int DIV_STAGES  = NUM_W / 2;
  localparam int QUEUE_DEPTH = 32;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int POS_W       = 58;
  localparam logic [1:0] FMT_CLUSTER = 2'd2;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {
    REG_FORMAT_VERSION    = 3'd0,
    REG_CLUSTER_SECTORS   = 3'd1,
    REG_FIRST_DATA_SECTOR = 3'd2,
    REG_DEVICE_SECTORS    = 3'd3,
    REG_FILE_BYTES        = 3'd4
  } sibt_reg_t;

  typedef enum logic {
    MODE_LOAD      = 1'b0,
    MODE_TRANSLATE = 1'b1
  } sibt_mode_t;

  typedef struct packed {
    logic [1:0]       fmt;
    logic [16:0]      csec;
    logic [31:0]      fds;
    logic [39:0]      dev;
    logic [POS_W-1:0] fbytes;
  } sibt_cfg_t;

  typedef struct packed {
    logic             mode;
    logic [15:0]      slot_index;
    logic [31:0]      slot_value;
    logic [NUM_W-1:0] num;
    logic [16:0]      rem;
    logic [8:0]       byte_lo;
    logic [31:0]      len;
    logic             off_past;
    logic             end_past;
  } sibt_item_t;

  function automatic sibt_item_t div_step(sibt_item_t x, logic [16:0] d);
    sibt_item_t  y;
    logic [17:0] t;
    y = x;
    for (int i = 0; i < 2; i++) begin
      t = {y.rem, y.num[NUM_W-1]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        y.num = {y.num[NUM_W-2:0], 1'b1};
      end else begin
        y.num = {y.num[NUM_W-2:0], 1'b0};
      end
      y.rem = t[16:0];
    end
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sparse_image_block_translate_core.sv =====
// A translate word passes from its accepting edge to its result at the outputs through the 21
// front-end divider registers, the queue and 4 back-end stages; one word per cycle while out_ready is
// high. Up to 32 words in flight; the cluster divider pipeline is the longest part of the path.
// Reset: synchronous; afterward a clearing pass zeroes the 65536-slot table, during which
// no word is accepted (configuration writes still taken).
`default_nettype none
module sparse_image_block_translate_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [57:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [15:0] slot_index,
  input  wire logic [31:0] slot_value,
  input  wire logic [48:0] read_offset,
  input  wire logic [31:0] read_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             mapped,
  output logic [57:0]      file_position,
  output logic             offset_past_device,
  output logic             end_past_device,
  output logic             end_past_file,
  output logic             crosses_cluster
);
  import sibt_pkg::*;

  logic [1:0]  format_version;
  logic [16:0] cluster_sectors;
  logic [31:0] first_data_sector;
  logic [39:0] device_sectors;
  logic [57:0] file_bytes;
  sibt_cfg_t   cfg;

  logic            accept, push, pop, empty, retire_load, clearing;
  sibt_item_t      push_item, head;
  logic [QUEUE_AW:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_version    <= 2'd2;
      cluster_sectors   <= 17'd2048;
      first_data_sector <= '0;
      device_sectors    <= '0;
      file_bytes        <= '0;
    end else if (cfg_we) begin
      case (sibt_reg_t'(cfg_index))
        REG_FORMAT_VERSION:    format_version    <= cfg_data[1:0];
        REG_CLUSTER_SECTORS:   cluster_sectors   <= cfg_data[16:0];
        REG_FIRST_DATA_SECTOR: first_data_sector <= cfg_data[31:0];
        REG_DEVICE_SECTORS:    device_sectors    <= cfg_data[39:0];
        REG_FILE_BYTES:        file_bytes        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.fmt    = format_version;
    cfg.csec   = (cluster_sectors == '0) ? 17'd1 : cluster_sectors;
    cfg.fds    = first_data_sector;
    cfg.dev    = device_sectors;
    cfg.fbytes = file_bytes;
  end

  assign in_ready = !clearing && (inflight != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + (QUEUE_AW+1)'(accept) - (QUEUE_AW+1)'(retire_load)
                  - (QUEUE_AW+1)'(out_valid && out_ready);
    end
  end

  sibt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mode        (mode),
    .slot_index  (slot_index),
    .slot_value  (slot_value),
    .read_offset (read_offset),
    .read_length (read_length),
    .cfg         (cfg),
    .push        (push),
    .item        (push_item)
  );

  sibt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  sibt_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .head               (head),
    .empty              (empty),
    .pop                (pop),
    .retire_load        (retire_load),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .mapped             (mapped),
    .file_position      (file_position),
    .offset_past_device (offset_past_device),
    .end_past_device    (end_past_device),
    .end_past_file      (end_past_file),
    .crosses_cluster    (crosses_cluster)
  );

endmodule
`default_nettype wire

// ===== rtl/core/sibt_front.sv =====
// Front end: accept words, compute device flags, split offset into cluster and remainder.
`default_nettype none
module sibt_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                mode,
  input  wire logic [15:0]         slot_index,
  input  wire logic [31:0]         slot_value,
  input  wire logic [48:0]         read_offset,
  input  wire logic [31:0]         read_length,
  input  wire sibt_pkg::sibt_cfg_t cfg,
  output logic                     push,
  output sibt_pkg::sibt_item_t     item
);
  import sibt_pkg::*;

  sibt_item_t st [DIV_STAGES+1];
  logic       v  [DIV_STAGES+1];
  logic [48:0] dev_bytes;
  logic [49:0] end_byte;

  assign dev_bytes = {cfg.dev, 9'b0};
  assign end_byte  = {1'b0, read_offset} + 50'(read_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= accept;
    end
    st[0].mode       <= mode;
    st[0].slot_index <= slot_index;
    st[0].slot_value <= slot_value;
    st[0].num        <= read_offset[48:9];
    st[0].rem        <= '0;
    st[0].byte_lo    <= read_offset[8:0];
    st[0].len        <= read_length;
    st[0].off_past   <= dev_bytes < read_offset;
    st[0].end_past   <= {1'b0, dev_bytes} < end_byte;
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v[k-1];
      end
      st[k] <= div_step(st[k-1], cfg.csec);
    end
  end

  assign push = v[DIV_STAGES];
  assign item = st[DIV_STAGES];

endmodule
`default_nettype wire

// ===== rtl/core/sibt_queue.sv =====
// Queue of classified words between front and back.
`default_nettype none
module sibt_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sibt_pkg::sibt_item_t push_item,
  input  wire logic                 pop,
  output sibt_pkg::sibt_item_t      head,
  output logic                      empty
);
  import sibt_pkg::*;

  sibt_item_t          entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sibt_back.sv =====
// Back end: allocation table, clearing pass, position arithmetic and result register.
`default_nettype none
module sibt_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sibt_pkg::sibt_cfg_t  cfg,
  input  wire sibt_pkg::sibt_item_t head,
  input  wire logic                 empty,
  output logic                      pop,
  output logic                      retire_load,
  output logic                      clearing,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      mapped,
  output logic [57:0]               file_position,
  output logic                      offset_past_device,
  output logic                      end_past_device,
  output logic                      end_past_file,
  output logic                      crosses_cluster
);
  import sibt_pkg::*;

  logic [31:0]        bat_mem [TABLE_SLOTS];
  logic [SLOT_AW-1:0] clr_addr;
  logic               adv;
  logic               is_load;
  logic               load_ok;
  logic               mem_we;
  logic [SLOT_AW-1:0] mem_wa;
  logic [31:0]        mem_wd;

  logic        s1_v, s1_range, s1_op, s1_ep;
  logic [31:0] rd;
  logic [25:0] s1_cin;
  logic [31:0] s1_len;

  logic        s2_v, s2_hit, s2_op, s2_ep;
  logic [31:0] s2_slot;
  logic [48:0] s2_prod;
  logic [25:0] s2_cin;
  logic [31:0] s2_len;
  logic [31:0] slot_m1;

  logic        s3_v, s3_hit, s3_op, s3_ep, s3_cross;
  logic [59:0] s3_pos;
  logic [31:0] s3_len;
  logic [59:0] pos_c2, pos_c1;
  logic [32:0] cin_end;

  assign adv         = !out_valid || out_ready;
  assign pop         = adv && !empty && !clearing;
  assign is_load     = (head.mode == MODE_LOAD);
  assign retire_load = pop && is_load;
  assign load_ok     = (32'(head.slot_index) < 32'(TABLE_SLOTS));

  assign mem_we = clearing || (retire_load && load_ok);
  assign mem_wa = clearing ? clr_addr : SLOT_AW'(head.slot_index);
  assign mem_wd = clearing ? 32'd0 : head.slot_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SLOT_AW'(TABLE_SLOTS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) bat_mem[mem_wa] <= mem_wd;
    if (pop) rd <= bat_mem[head.num[SLOT_AW-1:0]];
  end

  assign slot_m1 = rd - 32'd1;
  assign pos_c2  = {19'b0, cfg.fds, 9'b0} + {2'b0, s2_prod, 9'b0} + 60'(s2_cin);
  assign pos_c1  = {19'b0, s2_slot, 9'b0} + 60'(s2_cin);
  assign cin_end = 33'(s2_cin) + 33'(s2_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= pop && !is_load;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
    if (adv) begin
      s1_range <= (head.num < NUM_W'(TABLE_SLOTS));
      s1_cin   <= {head.rem, head.byte_lo};
      s1_len   <= head.len;
      s1_op    <= head.off_past;
      s1_ep    <= head.end_past;

      s2_hit   <= s1_range && (rd != 32'd0);
      s2_slot  <= rd;
      s2_prod  <= {17'b0, slot_m1} * {32'b0, cfg.csec};
      s2_cin   <= s1_cin;
      s2_len   <= s1_len;
      s2_op    <= s1_op;
      s2_ep    <= s1_ep;

      s3_hit   <= s2_hit;
      s3_pos   <= !s2_hit ? 60'd0 : (cfg.fmt == FMT_CLUSTER) ? pos_c2 : pos_c1;
      s3_cross <= cin_end > {7'b0, cfg.csec, 9'b0};
      s3_len   <= s2_len;
      s3_op    <= s2_op;
      s3_ep    <= s2_ep;

      mapped             <= s3_hit;
      file_position      <= (s3_pos > 60'(POS_MAX)) ? POS_MAX : s3_pos[POS_W-1:0];
      offset_past_device <= s3_op;
      end_past_device    <= s3_ep;
      end_past_file      <= s3_hit &&
                            ((61'(s3_pos) + 61'(s3_len)) > 61'(cfg.fbytes));
      crosses_cluster    <= s3_cross;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the sparse image allocation table translator: directed table, then random words.
`default_nettype none
module tb_top;
  import sibt_pkg::*;

  typedef struct packed {
    logic        mapped;
    logic [57:0] pos;
    logic        off_past;
    logic        end_past;
    logic        past_file;
    logic        crosses;
  } xlat_t;

  typedef struct {
    logic        mode;
    logic [15:0] sidx;
    logic [31:0] sval;
    logic [48:0] off;
    logic [31:0] len;
    bit          typed;
    xlat_t       res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [57:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic mode = 0;
  logic [15:0] slot_index = '0;
  logic [31:0] slot_value = '0;
  logic [48:0] read_offset = '0;
  logic [31:0] read_length = '0;
  logic out_valid;
  logic out_ready = 0;
  logic mapped, offset_past_device, end_past_device, end_past_file, crosses_cluster;
  logic [57:0] file_position;

  sparse_image_block_translate_core dut (.*);

  always #10 clk = ~clk;

  logic [31:0] bat [0:TABLE_SLOTS-1];
  logic [1:0]  fmt_r;
  logic [16:0] csec_r;
  logic [31:0] fds_r;
  logic [39:0] dev_r;
  logic [57:0] fbytes_r;

  xlat_t pending_xlat [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  int quiet = 0;
  row_t rows [7];

  function automatic xlat_t translate(logic [48:0] off, logic [31:0] len);
    xlat_t r;
    logic [63:0] cs, cb, cnum, cin, devb, fin, slot, p;
    logic [65:0] pe;
    cs = (csec_r == 0) ? 64'd1 : 64'(csec_r);
    cb = cs * 512;
    cnum = 64'(off) / cb;
    cin = 64'(off) % cb;
    devb = 64'(dev_r) * 512;
    fin = 64'(off) + 64'(len);
    r = '{default: 0};
    slot = 0;
    if (cnum < TABLE_SLOTS) slot = 64'(bat[cnum[15:0]]);
    if (slot != 0) begin
      r.mapped = 1;
      if (fmt_r == FMT_CLUSTER) pe = 66'(fds_r) * 512 + 66'(slot - 1) * 66'(cb) + 66'(cin);
      else pe = 66'(slot) * 512 + 66'(cin);
      r.past_file = (pe + 66'(len)) > 66'(fbytes_r);
      r.pos = (pe > 66'(POS_MAX)) ? POS_MAX : pe[57:0];
    end
    r.off_past = devb < 64'(off);
    r.end_past = devb < fin;
    r.crosses = (cin + 64'(len)) > cb;
    return r;
  endfunction

  task automatic write_reg(sibt_reg_t idx, logic [57:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_FORMAT_VERSION: fmt_r = val[1:0];
      REG_CLUSTER_SECTORS: csec_r = val[16:0];
      REG_FIRST_DATA_SECTOR: fds_r = val[31:0];
      REG_DEVICE_SECTORS: dev_r = val[39:0];
      default: fbytes_r = val;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(logic m, logic [15:0] si, logic [31:0] sv, logic [48:0] off,
                           logic [31:0] len, bit typed, xlat_t tr);
    xlat_t e;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    slot_index <= si;
    slot_value <= sv;
    read_offset <= off;
    read_length <= len;
    do @(posedge clk); while (!in_ready);
    if (m == MODE_LOAD) begin
      bat[si] = sv;
    end else begin
      e = typed ? tr : translate(off, len);
      pending_xlat = {pending_xlat, e};
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    xlat_t e, a;
    if (!rst && out_valid && out_ready) begin
      a = '{mapped, file_position, offset_past_device, end_past_device, end_past_file,
            crosses_cluster};
      if (pending_xlat.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $time, a);
      end else begin
        e = pending_xlat.pop_front();
        if (a != e) begin
          errors++;
          $display("%0t mismatch expected %p actual %p", $time, e, a);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic random_phase(int n);
    logic [15:0] si;
    logic [48:0] off;
    logic [31:0] len;
    logic [63:0] cb;
    for (int i = 0; i < n; i++) begin
      cb = 64'((csec_r == 0) ? 17'd1 : csec_r) * 512;
      si = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(63));
      if ($urandom_range(2) == 0) begin
        send_word(MODE_LOAD, si, ($urandom_range(5) == 0) ? 32'd0 : $urandom, 49'd0, 32'd0,
                  1'b0, '{default: 0});
      end else begin
        case ($urandom_range(3))
          0: off = 49'({$urandom, $urandom});
          default: off = 49'(64'($urandom_range(63)) * cb + 64'($urandom) % cb);
        endcase
        len = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(8192));
        send_word(MODE_TRANSLATE, 16'($urandom), $urandom, off, len, 1'b0, '{default: 0});
      end
    end
  endtask

  task automatic random_config;
    write_reg(REG_FORMAT_VERSION, 58'($urandom_range(3)));
    write_reg(REG_CLUSTER_SECTORS, ($urandom_range(4) == 0) ? 58'($urandom) & 58'h1FFFF
                                                            : 58'($urandom_range(64)));
    write_reg(REG_FIRST_DATA_SECTOR, 58'($urandom));
    write_reg(REG_DEVICE_SECTORS, 58'({$urandom, $urandom} & 64'hFF_FFFF_FFFF));
    write_reg(REG_FILE_BYTES, 58'({$urandom, $urandom}) & POS_MAX);
  endtask

  initial begin
    row_t r;
    xlat_t z;
    bat = '{default: '0};
    fmt_r = 2'd2; csec_r = 17'd2048; fds_r = '0; dev_r = '0; fbytes_r = '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    z = '{default: 0};
    // after reset: table empty, device size zero
    rows = '{
      '{MODE_TRANSLATE, 16'd0, 32'd0, 49'd0, 32'd0, 1'b1, z},
      '{MODE_TRANSLATE, 16'd0, 32'd0, 49'd1, 32'd0, 1'b1,
        '{1'b0, 58'd0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{MODE_TRANSLATE, 16'd0, 32'd0, '1, '1, 1'b1,
        '{1'b0, 58'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{MODE_LOAD, 16'd0, 32'd1, 49'd0, 32'd0, 1'b0, z},
      '{MODE_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 49'd0, 32'd0, 1'b0, z},
      '{MODE_TRANSLATE, 16'd0, 32'd0, 49'd0, 32'd512, 1'b0, z},
      '{MODE_TRANSLATE, 16'd0, 32'd0, 49'h1_0000_0000, 32'd1, 1'b0, z}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_word(r.mode, r.sidx, r.sval, r.off, r.len, r.typed, r.res);
    end
    drain();
    write_reg(REG_DEVICE_SECTORS, 58'hFF_FFFF_FFFF);
    write_reg(REG_FILE_BYTES, POS_MAX);
    write_reg(REG_FIRST_DATA_SECTOR, 58'hFFFF_FFFF);
    write_reg(REG_CLUSTER_SECTORS, 58'h1FFFF);
    send_word(MODE_TRANSLATE, 16'd0, 32'd0, 49'd0, 32'd0, 1'b0, z);
    send_word(MODE_TRANSLATE, 16'd0, 32'd0, '1, '1, 1'b0, z);
    drain();
    write_reg(REG_CLUSTER_SECTORS, 58'd0);
    write_reg(REG_FORMAT_VERSION, 58'd1);
    send_word(MODE_LOAD, 16'd3, 32'hFFFF_FFFF, 49'd0, 32'd0, 1'b0, z);
    send_word(MODE_TRANSLATE, 16'd0, 32'd0, 49'd2047, 32'd2, 1'b0, z);
    send_word(MODE_TRANSLATE, 16'd0, 32'd0, 49'h1FF_FFFF, 32'd7, 1'b0, z);
    drain();
    write_reg(REG_FORMAT_VERSION, 58'd3);
    write_reg(REG_CLUSTER_SECTORS, 58'd1);
    write_reg(REG_FILE_BYTES, 58'd0);
    write_reg(REG_DEVICE_SECTORS, 58'd0);
    send_word(MODE_TRANSLATE, 16'd0, 32'd0, 49'd1536, 32'd1, 1'b0, z);
    drain();
    write_reg(REG_FORMAT_VERSION, 58'd0);
    send_word(MODE_TRANSLATE, 16'd0, 32'd0, 49'd1537, 32'd600, 1'b0, z);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      random_config();
      case (ph)
        1: begin idle_pct = 88; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 88; end
        3: begin idle_pct = 34; stall_pct = 34; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
          random_phase(190);
        join
      end else begin
        random_phase(190);
      end
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
